// File: hdl/fba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the file block allocator.
// Used by file_block_allocator; depends on nothing else.
package fba_pkg;

   // Geometry of the disk and of the file tables.
   localparam int NUM_BLOCKS        = 1024;
   localparam int FILE_SLOTS        = 64;
   localparam int MAX_FILE_BLOCKS   = 35;
   localparam int DIRECT_BLOCKS     = 3;
   localparam int BLOCK_BYTES       = 128;
   localparam int OVERHEAD_BYTES    = 16 + 4 + 4 + 12 + 28 + 28;
   localparam int INDEX_ENTRY_BYTES = 4;
   localparam int SIZE_LIMIT        = BLOCK_BYTES * MAX_FILE_BLOCKS;
   localparam int TABLE_DEPTH       = FILE_SLOTS * MAX_FILE_BLOCKS;

   // Widths.
   localparam int BLK_W   = $clog2(NUM_BLOCKS);
   localparam int DEPTH_W = $clog2(NUM_BLOCKS + 1);
   localparam int SLOT_W  = $clog2(FILE_SLOTS);
   localparam int BYTES_W = 13;
   localparam int CNT_W   = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int TAB_W   = $clog2(TABLE_DEPTH);
   localparam int OFF_W   = $clog2(BLOCK_BYTES);
   localparam int STAT_W  = 3;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 40;

   // Operation codes.
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_FORMAT = 2'd3;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
   localparam logic [STAT_W-1:0] ST_DISK_FULL = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STAT_W-1:0] ST_BUSY      = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_META,
      S_FILL,
      S_MOVE_RD,
      S_MOVE_WR,
      S_SINGLE
   } state_type;

   // One result beat.
   typedef struct packed {
      logic [DEPTH_W-1:0] free_count;
      logic [BYTES_W-1:0] total_bytes;
      logic               in_index;
      logic               block_valid;
      logic [BLK_W-1:0]   block_number;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   // Per-slot bookkeeping kept in the metadata memory.
   typedef struct packed {
      logic [BYTES_W-1:0] total;
      logic [CNT_W-1:0]   count;
   } meta_type;

endpackage

// File: hdl/file_block_allocator.sv
`timescale 1ns / 1ps
// File block allocator: free block stack, per-slot block tables and metadata.
// Depends on fba_pkg.
//
// Usage:
//  - req_* carries one operation per beat: create, append, delete or format.
//  - rsp_* returns one beat per block moved (popped or pushed), or one beat
//    when no block moves; rsp_tlast marks the final beat of an operation.
//  - csr_* writes the disk block count used by format; write only while idle.
// Timing:
//  - An operation first reads and checks the slot metadata, then moves each
//    block as a read and then a write back, set by the single read port of the
//    free stack and of the block table.
//  - Format writes one stack entry per cycle.
//  - One operation is in flight at a time; req_tready is high only when idle.
// Reset clears the stack depth to zero and frees every slot; the stack stays
// empty until the first format. The disk block count resets to 1024.
// A stalled receiver holds the current beat in the output register and the
// block pauses before its next memory read until the beat is taken.
module file_block_allocator
   import fba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Request: [1:0] opcode, [7:2] file_slot, [20:8] byte_count, zero padded.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // Response: [2:0] status, [12:3] block_number, [13] block_valid,
   // [14] in_index, [27:15] total_bytes, [38:28] free_count, zero padded.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   // Disk block count register.
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);

   // Control and pending-result registers.
   state_type              state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [BYTES_W-1:0]     bytes_ff, bytes_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   logic [10:0]            disk_ff;
   logic [FILE_SLOTS-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]       mv_cnt_ff, mv_cnt_in;
   logic [CNT_W-1:0]       mv_idx_ff, mv_idx_in;
   logic [TAB_W-1:0]       base_ff, base_in;
   logic                   pop_ff, pop_in;
   logic [STAT_W-1:0]      pend_stat_ff, pend_stat_in;
   logic [BYTES_W-1:0]     pend_total_ff, pend_total_in;
   logic [DEPTH_W-1:0]     fill_ff, fill_in;
   logic [DEPTH_W-1:0]     cap_ff, cap_in;
   rsp_type                out_ff;
   logic                   out_valid_ff, out_last_ff;

   // Memories.
   logic [BLK_W-1:0]   stack_mem [NUM_BLOCKS];
   logic [BLK_W-1:0]   table_mem [TABLE_DEPTH];
   meta_type           meta_mem  [FILE_SLOTS];
   logic [BLK_W-1:0]   stack_q_ff, table_q_ff;
   meta_type           meta_q_ff;

   // Memory port controls.
   logic               stack_we, stack_re, table_we, table_re, meta_we, meta_re;
   logic [BLK_W-1:0]   stack_waddr, stack_raddr, stack_wdata, table_wdata;
   logic [TAB_W-1:0]   table_waddr, table_raddr;
   logic [SLOT_W-1:0]  meta_raddr;
   meta_type           meta_wdata;

   // Output beat loading.
   logic               emit, emit_last, out_free;
   rsp_type            emit_data;

   // Metadata check arithmetic.
   logic               slot_used;
   logic [BYTES_W:0]   c_total, c_final, a_sum_bytes, a_final;
   logic [CNT_W:0]     c_need, a_need, a_sum, a_lo, cnt_sat;
   logic [OFF_W:0]     a_left;
   logic [OFF_W-1:0]   a_rem;
   logic [BYTES_W:0]   a_over;
   logic [DEPTH_W-1:0] fmt_cap;
   logic [BLK_W-1:0]   mv_blk;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - $bits(rsp_type)){1'b0}}, out_ff};
   assign rsp_tlast  = out_last_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign slot_used  = used_ff[slot_ff];
   assign mv_blk     = pop_ff ? stack_q_ff : table_q_ff;

   // Create and append sizing, from the latched request and stored metadata.
   always_comb begin
      c_total     = {1'b0, bytes_ff} + (BYTES_W+1)'(OVERHEAD_BYTES);
      c_need      = (CNT_W+1)'((c_total + (BYTES_W+1)'(BLOCK_BYTES - 1)) >> OFF_W);
      c_final     = c_total + ((c_need > (CNT_W+1)'(DIRECT_BLOCKS)) ?
                    (BYTES_W+1)'((c_need - (CNT_W+1)'(DIRECT_BLOCKS)) * INDEX_ENTRY_BYTES)
                    : '0);
      a_rem       = meta_q_ff.total[OFF_W-1:0];
      a_left      = (a_rem != '0) ? ((OFF_W+1)'(BLOCK_BYTES) - {1'b0, a_rem}) : '0;
      a_over      = {1'b0, bytes_ff} - (BYTES_W+1)'(a_left);
      a_need      = ({1'b0, bytes_ff} > (BYTES_W+1)'(a_left)) ?
                    (CNT_W+1)'((a_over + (BYTES_W+1)'(BLOCK_BYTES - 1)) >> OFF_W) : '0;
      a_sum       = {1'b0, meta_q_ff.count} + a_need;
      a_lo        = (meta_q_ff.count > CNT_W'(DIRECT_BLOCKS)) ?
                    {1'b0, meta_q_ff.count} : (CNT_W+1)'(DIRECT_BLOCKS);
      a_sum_bytes = {1'b0, bytes_ff} + {1'b0, meta_q_ff.total};
      a_final     = a_sum_bytes + ((a_sum > a_lo) ?
                    (BYTES_W+1)'((a_sum - a_lo) * INDEX_ENTRY_BYTES) : '0);
      cnt_sat     = (meta_q_ff.count > CNT_W'(MAX_FILE_BLOCKS)) ?
                    (CNT_W+1)'(MAX_FILE_BLOCKS) : {1'b0, meta_q_ff.count};
      fmt_cap     = (disk_ff > 11'(NUM_BLOCKS)) ? DEPTH_W'(NUM_BLOCKS) : DEPTH_W'(disk_ff);
   end

   // Next state, memory controls and result beats.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      bytes_in      = bytes_ff;
      depth_in      = depth_ff;
      used_in       = used_ff;
      mv_cnt_in     = mv_cnt_ff;
      mv_idx_in     = mv_idx_ff;
      base_in       = base_ff;
      pop_in        = pop_ff;
      pend_stat_in  = pend_stat_ff;
      pend_total_in = pend_total_ff;
      fill_in       = fill_ff;
      cap_in        = cap_ff;
      stack_we      = 1'b0;
      stack_re      = 1'b0;
      table_we      = 1'b0;
      table_re      = 1'b0;
      meta_we       = 1'b0;
      meta_re       = 1'b0;
      stack_waddr   = '0;
      stack_raddr   = '0;
      stack_wdata   = '0;
      table_waddr   = '0;
      table_raddr   = '0;
      table_wdata   = '0;
      meta_raddr    = '0;
      meta_wdata    = '0;
      emit          = 1'b0;
      emit_last     = 1'b0;
      emit_data     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tdata[1:0];
               slot_in    = req_tdata[7:2];
               bytes_in   = req_tdata[20:8];
               meta_re    = 1'b1;
               meta_raddr = req_tdata[7:2];
               state_in   = S_META;
            end
         end

         // Checks come before any change of state.
         S_META: begin
            base_in   = TAB_W'(slot_ff * MAX_FILE_BLOCKS);
            mv_idx_in = '0;
            state_in  = S_SINGLE;
            unique case (op_ff)
               OP_CREATE: begin
                  pop_in        = 1'b1;
                  pend_total_in = '0;
                  if (slot_used) begin
                     pend_stat_in  = ST_BUSY;
                     pend_total_in = meta_q_ff.total;
                  end else if (c_total > (BYTES_W+1)'(SIZE_LIMIT)) begin
                     pend_stat_in = ST_TOO_LARGE;
                  end else if ({{(DEPTH_W-CNT_W-1){1'b0}}, c_need} > depth_ff) begin
                     pend_stat_in = ST_DISK_FULL;
                  end else begin
                     pend_stat_in     = ST_OK;
                     pend_total_in    = BYTES_W'(c_final);
                     mv_cnt_in        = CNT_W'(c_need);
                     used_in[slot_ff] = 1'b1;
                     meta_we          = 1'b1;
                     meta_wdata.total = BYTES_W'(c_final);
                     meta_wdata.count = CNT_W'(c_need);
                     state_in         = S_MOVE_RD;
                  end
               end
               OP_APPEND: begin
                  pop_in        = 1'b1;
                  mv_idx_in     = meta_q_ff.count;
                  pend_total_in = meta_q_ff.total;
                  if (!slot_used) begin
                     pend_stat_in  = ST_EMPTY;
                     pend_total_in = '0;
                  end else if (a_sum_bytes > (BYTES_W+1)'(SIZE_LIMIT) ||
                               a_sum > (CNT_W+1)'(MAX_FILE_BLOCKS)) begin
                     pend_stat_in = ST_TOO_LARGE;
                  end else if ({{(DEPTH_W-CNT_W-1){1'b0}}, a_need} > depth_ff) begin
                     pend_stat_in = ST_DISK_FULL;
                  end else begin
                     pend_stat_in     = ST_OK;
                     pend_total_in    = BYTES_W'(a_final);
                     mv_cnt_in        = CNT_W'(a_need);
                     meta_we          = 1'b1;
                     meta_wdata.total = BYTES_W'(a_final);
                     meta_wdata.count = CNT_W'(a_sum);
                     if (a_need != '0) begin
                        state_in = S_MOVE_RD;
                     end
                  end
               end
               OP_DELETE: begin
                  pop_in        = 1'b0;
                  pend_total_in = '0;
                  if (!slot_used) begin
                     pend_stat_in = ST_EMPTY;
                  end else begin
                     pend_stat_in     = ST_OK;
                     mv_cnt_in        = CNT_W'(cnt_sat);
                     used_in[slot_ff] = 1'b0;
                     if (cnt_sat != '0) begin
                        state_in = S_MOVE_RD;
                     end
                  end
               end
               OP_FORMAT: begin
                  pend_stat_in  = ST_OK;
                  pend_total_in = '0;
                  used_in       = '0;
                  depth_in      = fmt_cap;
                  cap_in        = fmt_cap;
                  fill_in       = '0;
                  if (fmt_cap != '0) begin
                     state_in = S_FILL;
                  end
               end
               default: state_in = S_SINGLE;
            endcase
         end

         // Load the stack bottom-up so that block 0 ends on top.
         S_FILL: begin
            stack_we    = 1'b1;
            stack_waddr = BLK_W'(fill_ff);
            stack_wdata = BLK_W'(cap_ff - 1'b1 - fill_ff);
            fill_in     = fill_ff + 1'b1;
            if (fill_ff == cap_ff - 1'b1) begin
               state_in = S_SINGLE;
            end
         end

         // Read the next block: top of stack for a pop, table entry for a push.
         S_MOVE_RD: begin
            if (out_free) begin
               if (pop_ff) begin
                  stack_re    = 1'b1;
                  stack_raddr = BLK_W'(depth_ff - 1'b1);
                  depth_in    = depth_ff - 1'b1;
               end else begin
                  table_re    = 1'b1;
                  table_raddr = base_ff + TAB_W'(mv_idx_ff);
               end
               state_in = S_MOVE_WR;
            end
         end

         // Write the block to its destination and send its beat.
         S_MOVE_WR: begin
            if (pop_ff) begin
               table_we    = 1'b1;
               table_waddr = base_ff + TAB_W'(mv_idx_ff);
               table_wdata = mv_blk;
            end else if (depth_ff < DEPTH_W'(NUM_BLOCKS)) begin
               stack_we    = 1'b1;
               stack_waddr = BLK_W'(depth_ff);
               stack_wdata = mv_blk;
               depth_in    = depth_ff + 1'b1;
            end
            emit                   = 1'b1;
            emit_last              = (mv_cnt_ff == CNT_W'(1));
            emit_data.status       = ST_OK;
            emit_data.block_number = mv_blk;
            emit_data.block_valid  = 1'b1;
            emit_data.in_index     = (mv_idx_ff >= CNT_W'(DIRECT_BLOCKS));
            emit_data.total_bytes  = pend_total_ff;
            emit_data.free_count   = depth_in;
            mv_cnt_in              = mv_cnt_ff - 1'b1;
            mv_idx_in              = mv_idx_ff + 1'b1;
            state_in               = (mv_cnt_ff == CNT_W'(1)) ? S_IDLE : S_MOVE_RD;
         end

         // One beat without a block.
         S_SINGLE: begin
            if (out_free) begin
               emit                  = 1'b1;
               emit_last             = 1'b1;
               emit_data.status      = pend_stat_ff;
               emit_data.total_bytes = pend_total_ff;
               emit_data.free_count  = depth_ff;
               state_in              = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         used_ff      <= '0;
         disk_ff      <= 11'(NUM_BLOCKS);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         used_ff      <= used_in;
         out_valid_ff <= emit || (out_valid_ff && !rsp_tready);
         if (csr_valid) begin
            disk_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      bytes_ff      <= bytes_in;
      mv_cnt_ff     <= mv_cnt_in;
      mv_idx_ff     <= mv_idx_in;
      base_ff       <= base_in;
      pop_ff        <= pop_in;
      pend_stat_ff  <= pend_stat_in;
      pend_total_ff <= pend_total_in;
      fill_ff       <= fill_in;
      cap_ff        <= cap_in;
      if (emit) begin
         out_ff      <= emit_data;
         out_last_ff <= emit_last;
      end
   end

   // Free block stack.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_q_ff <= stack_mem[stack_raddr];
      end
   end

   // Per-slot block tables.
   always_ff @(posedge clock) begin
      if (table_we) begin
         table_mem[table_waddr] <= table_wdata;
      end
      if (table_re) begin
         table_q_ff <= table_mem[table_raddr];
      end
   end

   // Per-slot size and block count.
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[slot_ff] <= meta_wdata;
      end
      if (meta_re) begin
         meta_q_ff <= meta_mem[meta_raddr];
      end
   end

`ifndef SYNTHESIS
   // The stack never holds more than NUM_BLOCKS blocks.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(NUM_BLOCKS))
      else $error("stack depth exceeds block count");

   // A block beat is only produced when the output register can take it.
   a_move_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE_WR |-> !out_valid_ff)
      else $error("block beat would overwrite a pending beat");

   // An accepted request always starts the metadata check.
   a_accept_meta: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_META)
      else $error("request accepted without metadata check");

   // A pop never runs on an empty stack.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE_RD && pop_ff && out_free |-> depth_ff != '0)
      else $error("pop from empty stack");
`endif

endmodule
